// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the directory RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define RVD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/rvd_pkg.sv =====
// Shared types, codes and helpers for the region validity directory.
// Used by rvd_order_unit and region_validity_directory; no dependencies.
`timescale 1ns / 1ps

package rvd_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned VldW  = 8;
  localparam logic [2:0]  MaxDevices = 3'd7;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SYNC = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_BAD_MODE  = 3'd3;
  localparam logic [2:0] ST_BAD_DEV   = 3'd4;

  localparam logic [2:0] CFG_OBJECT_SIZE   = 3'd0;
  localparam logic [2:0] CFG_NUM_DEVICES   = 3'd1;
  localparam logic [2:0] CFG_ALIAS_MASK    = 3'd2;
  localparam logic [2:0] CFG_USE_HOST_PTR  = 3'd3;
  localparam logic [2:0] CFG_COPY_HOST_PTR = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
    logic [VldW-1:0]  valid;
  } entry_t;

  typedef struct packed {
    logic            need;
    logic [2:0]      src;
    logic [2:0]      dst;
    logic [VldW-1:0] new_valid;
  } ord_t;

  // Set the host bit and every aliasing device below the host slot.
  function automatic logic [VldW-1:0] host_rule(input logic [VldW-1:0] v,
                                                input logic [2:0] nd,
                                                input logic [6:0] alias_m);
    logic [8:0] low;
    low = (9'd1 << nd) - 9'd1;
    return v | (8'd1 << nd) | ({1'b0, alias_m} & low[7:0]);
  endfunction

endpackage

// ===== hdl/rvd_order_unit.sv =====
// Copy-order decision and valid-bit update for one chunk.
// Depends on rvd_pkg.
`timescale 1ns / 1ps

module rvd_order_unit import rvd_pkg::*; (
  input  logic [VldW-1:0] v_i,
  input  logic [2:0]      nd_i,
  input  logic [2:0]      dev_i,
  input  logic            devupd_i,
  input  logic            wr_i,
  input  logic [6:0]      alias_mask_i,
  output ord_t            ord_o
);

  logic [VldW-1:0] vm;
  logic [VldW-1:0] vv;
  logic [7:0]      al;
  logic [2:0]      lo;
  logic [VldW-1:0] nv;

  // Find the lowest valid slot among the live bits
  always_comb begin
    vm = 8'hFF >> (3'd7 - nd_i);
    vv = v_i & vm;
    al = {1'b0, alias_mask_i};
    lo = 3'd7;
    for (int b = 7; b >= 0; b--) begin
      if (vv[b]) lo = 3'(b);
    end
  end

  // Decide the order and compute the updated bits
  always_comb begin
    ord_o = '0;
    if (devupd_i) begin
      ord_o.dst = dev_i;
      ord_o.src = vv[nd_i] ? nd_i : lo;
      ord_o.need = (vv != '0) && !vv[dev_i] && !(vv[nd_i] && al[dev_i]);
    end else begin
      ord_o.dst = nd_i;
      ord_o.src = lo;
      ord_o.need = (vv != '0) && !vv[nd_i];
    end
    nv = wr_i ? '0 : v_i;
    if (devupd_i) begin
      nv = nv | (8'd1 << dev_i);
      if (al[dev_i]) nv = host_rule(nv, nd_i, alias_mask_i);
    end else begin
      nv = host_rule(nv, nd_i, alias_mask_i);
    end
    ord_o.new_valid = nv;
  end

endmodule

// ===== hdl/region_validity_directory.sv =====
// Top level of the region validity directory: chunk table, sequencer, ports.
// Depends on rvd_pkg, rvd_order_unit and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage: raise start with a command on cmd_i and its operands while busy is
// low; the command is taken at that edge and busy rises on the next cycle.
// Results come back on the res_* ports, one per cycle at most, each marked
// by res_valid_o for exactly one cycle: zero or more copy orders, then one
// status item with last_o set. The receiver cannot stall; results are taken
// as they appear. Configuration registers are written through cfg_valid_i /
// cfg_ready_o with cfg_index_i and cfg_data_i while no command is running.
// Init writes its first entry and then issues its status item. Add-region
// scans the table with a read and an evaluate state per entry; each split
// then moves the entries above the split point with a read and a write
// state per entry and writes the two halves. Sync reads and evaluates each
// entry and, for an overlapping one, emits its copy orders and writes back
// the valid bits. The chunk memory has a write port and a registered read.
// Reset empties the table and loads the default configuration.

module region_validity_directory import rvd_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       cmd_i,
  input  logic [31:0]      offset_i,
  input  logic [31:0]      size_i,
  input  logic             sync_read_i,
  input  logic             sync_write_i,
  input  logic             sync_map_i,
  input  logic [2:0]       device_i,
  output logic             res_valid_o,
  output logic             is_transfer_o,
  output logic [2:0]       src_index_o,
  output logic [2:0]       dst_index_o,
  output logic [31:0]      chunk_offset_o,
  output logic [31:0]      chunk_size_o,
  output logic [2:0]       status_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned IW = $clog2(MAX_CHUNKS);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CHK  = 13'b0000000000010,
    S_RD   = 13'b0000000000100,
    S_EV   = 13'b0000000001000,
    S_EM1  = 13'b0000000010000,
    S_EM2  = 13'b0000000100000,
    S_WB   = 13'b0000001000000,
    S_SPL  = 13'b0000010000000,
    S_SHRD = 13'b0000100000000,
    S_SHWR = 13'b0001000000000,
    S_SPA  = 13'b0010000000000,
    S_SPB  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_e;

  // Configuration registers
  logic [31:0] object_size_q;
  logic [2:0]  num_devices_q;
  logic [6:0]  alias_mask_q;
  logic        use_host_q;
  logic        copy_host_q;

  // Sequencer and command registers
  state_e      state_q, state_d;
  cmd_e        cmd_q;
  logic [31:0] off_q, len_q, e_q;
  logic        rd_q, wr_q, mp_q;
  logic [2:0]  dev_q;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] te_q, te_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]  stat_q, stat_d;

  // Current entry during a sync scan
  entry_t      cur_q, cur_d;
  logic [31:0] cur_end_q, cur_end_d;
  logic        p1_q, p1_d, p2_q, p2_d;

  // Split points found during an add scan
  logic        fa_q, fa_d, fb_q, fb_d;
  logic [IW-1:0] ia_q, ia_d, ib_q, ib_d;
  entry_t      a_q, a_d, b_q, b_d;
  logic [31:0] a_end_q, a_end_d, b_end_q, b_end_d;
  logic        sa_q, sa_d, sb_q, sb_d, sp_second_q, sp_second_d;

  // Split engine
  logic [IW-1:0] sp_i_q, sp_i_d;
  logic [CW-1:0] j_q, j_d;
  logic [31:0] sp_pos_q, sp_pos_d, sp_cs_q, sp_cs_d, sp_ce_q, sp_ce_d;
  logic [VldW-1:0] sp_v_q, sp_v_d;

  // Result registers
  logic        res_valid_q, res_valid_d;
  logic        tr_q, tr_d;
  logic [2:0]  src_q, src_d, dst_q, dst_d;
  logic [31:0] coff_q, coff_d, csz_q, csz_d;
  logic [2:0]  rst_q, rst_d;
  logic        last_q, last_d;

  // Chunk memory
  entry_t      mem [MAX_CHUNKS];
  entry_t      rdata_q;
  logic [IW-1:0] raddr;
  logic        we;
  logic [IW-1:0] waddr;
  entry_t      wdata;

  logic [2:0]  nd;
  logic        devupd;
  logic        accept;
  logic        range_bad;
  logic [31:0] r_end;
  logic        last_idx;
  logic [CW-1:0] ip1;
  ord_t        ord;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  assign nd       = (num_devices_q > MaxDevices) ? MaxDevices : num_devices_q;
  assign devupd   = !(mp_q && use_host_q);
  assign r_end    = rdata_q.start + rdata_q.len;
  assign last_idx = ({1'b0, idx_q} == (count_q - CW'(1)));
  assign ip1      = CW'(sp_i_q) + CW'(1);
  assign range_bad = (len_q == '0) || (count_q == '0) || (off_q >= te_q) ||
                     (len_q > (te_q - off_q));

  rvd_order_unit u_order (
    .v_i          (cur_q.valid),
    .nd_i         (nd),
    .dev_i        (dev_q),
    .devupd_i     (devupd),
    .wr_i         (wr_q),
    .alias_mask_i (alias_mask_q),
    .ord_o        (ord)
  );

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      object_size_q <= 32'd4096;
      num_devices_q <= 3'd1;
      alias_mask_q  <= '0;
      use_host_q    <= 1'b0;
      copy_host_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OBJECT_SIZE:   object_size_q <= cfg_data_i;
        CFG_NUM_DEVICES:   num_devices_q <= cfg_data_i[2:0];
        CFG_ALIAS_MASK:    alias_mask_q  <= cfg_data_i[6:0];
        CFG_USE_HOST_PTR:  use_host_q    <= cfg_data_i[0];
        CFG_COPY_HOST_PTR: copy_host_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Read and write the chunk memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    raddr = (state_q == S_SHRD) ? IW'(j_q - CW'(1)) : idx_q;
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    te_d = te_q;
    idx_d = idx_q;
    stat_d = stat_q;
    cur_d = cur_q;
    cur_end_d = cur_end_q;
    p1_d = p1_q;
    p2_d = p2_q;
    fa_d = fa_q;
    fb_d = fb_q;
    ia_d = ia_q;
    ib_d = ib_q;
    a_d = a_q;
    b_d = b_q;
    a_end_d = a_end_q;
    b_end_d = b_end_q;
    sa_d = sa_q;
    sb_d = sb_q;
    sp_second_d = sp_second_q;
    sp_i_d = sp_i_q;
    j_d = j_q;
    sp_pos_d = sp_pos_q;
    sp_cs_d = sp_cs_q;
    sp_ce_d = sp_ce_q;
    sp_v_d = sp_v_q;
    res_valid_d = 1'b0;
    tr_d = 1'b0;
    src_d = '0;
    dst_d = '0;
    coff_d = '0;
    csz_d = '0;
    rst_d = ST_OK;
    last_d = 1'b0;
    we = 1'b0;
    waddr = idx_q;
    wdata = cur_q;

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CHK;
      end
      S_CHK: begin
        stat_d = ST_OK;
        idx_d = '0;
        fa_d = 1'b0;
        fb_d = 1'b0;
        sp_second_d = 1'b0;
        state_d = S_DONE;
        case (cmd_q)
          CMD_INIT: begin
            if (object_size_q == '0) begin
              count_d = '0;
              te_d = '0;
              stat_d = ST_BAD_RANGE;
            end else begin
              we = 1'b1;
              waddr = '0;
              wdata.start = '0;
              wdata.len = object_size_q;
              wdata.valid = use_host_q ? host_rule('0, nd, alias_mask_q) : '0;
              if (copy_host_q && nd != 3'd0) wdata.valid[0] = 1'b1;
              count_d = CW'(1);
              te_d = object_size_q;
            end
          end
          CMD_ADD: begin
            if (range_bad) stat_d = ST_BAD_RANGE;
            else state_d = S_RD;
          end
          CMD_SYNC: begin
            if (!rd_q && !wr_q) stat_d = ST_BAD_MODE;
            else if (dev_q >= nd) stat_d = ST_BAD_DEV;
            else if (range_bad) stat_d = ST_BAD_RANGE;
            else state_d = S_RD;
          end
          default: stat_d = ST_BAD_MODE;
        endcase
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        if (cmd_q == CMD_ADD) begin
          // Record the chunks holding both region ends
          if (!fa_q && (off_q < r_end)) begin
            fa_d = 1'b1;
            ia_d = idx_q;
            a_d = rdata_q;
            a_end_d = r_end;
          end
          if (!fb_q && (e_q < r_end)) begin
            fb_d = 1'b1;
            ib_d = idx_q;
            b_d = rdata_q;
            b_end_d = r_end;
          end
          if (last_idx) state_d = S_SPL;
          else begin
            idx_d = idx_q + IW'(1);
            state_d = S_RD;
          end
        end else begin
          cur_d = rdata_q;
          cur_end_d = r_end;
          p1_d = rd_q || (rdata_q.start < off_q);
          p2_d = !rd_q && (r_end > e_q);
          if ((rdata_q.start < e_q) && (r_end > off_q)) state_d = S_EM1;
          else if (last_idx) state_d = S_DONE;
          else begin
            idx_d = idx_q + IW'(1);
            state_d = S_RD;
          end
        end
      end
      S_EM1: begin
        if (p1_q && ord.need) begin
          res_valid_d = 1'b1;
          tr_d = 1'b1;
          src_d = ord.src;
          dst_d = ord.dst;
          coff_d = cur_q.start;
          csz_d = rd_q ? cur_q.len : (off_q - cur_q.start);
        end
        state_d = S_EM2;
      end
      S_EM2: begin
        if (p2_q && ord.need) begin
          res_valid_d = 1'b1;
          tr_d = 1'b1;
          src_d = ord.src;
          dst_d = ord.dst;
          coff_d = e_q;
          csz_d = cur_end_q - e_q;
        end
        state_d = S_WB;
      end
      S_WB: begin
        we = 1'b1;
        waddr = idx_q;
        wdata = cur_q;
        wdata.valid = ord.new_valid;
        if (last_idx) state_d = S_DONE;
        else begin
          idx_d = idx_q + IW'(1);
          state_d = S_RD;
        end
      end
      S_SPL: begin
        if (!sp_second_q) begin
          sa_d = (a_q.start != off_q);
          sb_d = fb_q && (b_q.start != e_q);
          if (({1'b0, count_q} + (CW + 1)'(sa_d) + (CW + 1)'(sb_d)) >
              (CW + 1)'(MAX_CHUNKS)) begin
            stat_d = ST_FULL;
            state_d = S_DONE;
          end else begin
            sp_second_d = 1'b1;
            if (sa_d) begin
              sp_i_d = ia_q;
              sp_pos_d = off_q;
              sp_cs_d = a_q.start;
              sp_ce_d = a_end_q;
              sp_v_d = a_q.valid;
              j_d = count_q;
              state_d = (count_q > (CW'(ia_q) + CW'(1))) ? S_SHRD : S_SPA;
            end
          end
        end else if (sb_q) begin
          sb_d = 1'b0;
          sp_i_d = ib_q + IW'(sa_q);
          sp_pos_d = e_q;
          sp_cs_d = (sa_q && (ia_q == ib_q)) ? off_q : b_q.start;
          sp_ce_d = b_end_q;
          sp_v_d = b_q.valid;
          j_d = count_q;
          state_d = (count_q > (CW'(sp_i_d) + CW'(1))) ? S_SHRD : S_SPA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHRD: begin
        state_d = S_SHWR;
      end
      S_SHWR: begin
        // Move one entry up by one place
        we = 1'b1;
        waddr = IW'(j_q);
        wdata = rdata_q;
        j_d = j_q - CW'(1);
        state_d = (j_d > ip1) ? S_SHRD : S_SPA;
      end
      S_SPA: begin
        we = 1'b1;
        waddr = sp_i_q;
        wdata.start = sp_cs_q;
        wdata.len = sp_pos_q - sp_cs_q;
        wdata.valid = sp_v_q;
        state_d = S_SPB;
      end
      S_SPB: begin
        we = 1'b1;
        waddr = IW'(ip1);
        wdata.start = sp_pos_q;
        wdata.len = sp_ce_q - sp_pos_q;
        wdata.valid = sp_v_q;
        count_d = count_q + CW'(1);
        state_d = S_SPL;
      end
      S_DONE: begin
        res_valid_d = 1'b1;
        rst_d = stat_q;
        last_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      off_q <= offset_i;
      len_q <= size_i;
      e_q <= offset_i + size_i;
      rd_q <= sync_read_i;
      wr_q <= sync_write_i;
      mp_q <= sync_map_i;
      dev_q <= device_i;
    end
    te_q <= te_d;
    idx_q <= idx_d;
    stat_q <= stat_d;
    cur_q <= cur_d;
    cur_end_q <= cur_end_d;
    p1_q <= p1_d;
    p2_q <= p2_d;
    fa_q <= fa_d;
    fb_q <= fb_d;
    ia_q <= ia_d;
    ib_q <= ib_d;
    a_q <= a_d;
    b_q <= b_d;
    a_end_q <= a_end_d;
    b_end_q <= b_end_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
    sp_second_q <= sp_second_d;
    sp_i_q <= sp_i_d;
    j_q <= j_d;
    sp_pos_q <= sp_pos_d;
    sp_cs_q <= sp_cs_d;
    sp_ce_q <= sp_ce_d;
    sp_v_q <= sp_v_d;
    tr_q <= tr_d;
    src_q <= src_d;
    dst_q <= dst_d;
    coff_q <= coff_d;
    csz_q <= csz_d;
    rst_q <= rst_d;
    last_q <= last_d;
  end

  assign res_valid_o    = res_valid_q;
  assign is_transfer_o  = tr_q;
  assign src_index_o    = src_q;
  assign dst_index_o    = dst_q;
  assign chunk_offset_o = coff_q;
  assign chunk_size_o   = csz_q;
  assign status_o       = rst_q;
  assign last_o         = last_q;

  `RVD_ASSERT(a_status_when_idle, (res_valid_o && last_o) |-> !busy, "status item while busy")
  `RVD_ASSERT(a_order_while_busy, (res_valid_o && is_transfer_o) |-> busy, "copy order after end")
  `RVD_ASSERT_NEXT(a_accept_checks, start && !busy, state_q == S_CHK, "request not taken")
  `RVD_ASSERT_NEXT(a_split_grows, state_q == S_SPB, count_q == $past(count_q) + CW'(1), "split lost")

endmodule
